// File: rtl/core/txcon_pkg.sv
// Shared types and constants for the text console cursor control block.
// No dependencies.
package txcon_pkg;

  // Character codes with a special meaning
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_TAB       = 8'd9;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  // Configuration register indexes
  localparam logic [7:0] CFG_COLUMN_COUNT = 8'd0;
  localparam logic [7:0] CFG_ROW_COUNT    = 8'd1;

  // Register reset values
  localparam logic [7:0] COLUMN_COUNT_RST = 8'd180;
  localparam logic [7:0] ROW_COUNT_RST    = 8'd61;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 88;

  // Cursor position on the text grid
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } cursor_t;

endpackage

// File: rtl/core/text_console_cursor_control.sv
// Text console cursor control: top level.
// Tracks the cursor and turns characters into cell writes. Uses txcon_pkg.
//
// Usage:
//   s_axis: one character per transaction. tdata = {bg_color, fg_color, char_code}.
//   m_axis: one cell write per transaction, tlast marks the final cell of a character.
//   cfg:    register writes (index 0 column_count, index 1 row_count), always ready;
//           write only while the block is idle. A count of 0 acts as 1.
// Path: a character waits in the input register, is loaded into the emit sequencer
//   and has its first cell write registered in the output register.
// Throughput: one cell write per cycle from the emit sequencer, unless stalled.
//   A printable character or backspace emits one cell, a tab one space per
//   column up to the next tab stop (up to TAB_STOP), a newline nothing. The
//   next character is loaded in the cycle the previous one emits its final cell.
// Reset: cursor goes to column 0, row 0; registers take 180 columns by 61 rows;
//   input, sequencer and output register are emptied.
// Stall: while m_axis_tready is low the output register holds its cell, the
//   sequencer waits and one further character is held in the input register;
//   s_axis_tready drops once that register is full.
module text_console_cursor_control
  import txcon_pkg::*;
#(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Character input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] char_code, [39:8] fg_color, [71:40] bg_color
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Cell write output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] cell_column, [15:8] cell_row, [23:16] glyph_code,
  // [55:24] draw_fg, [87:56] draw_bg
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,   // last_cell
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  localparam int unsigned RW = $clog2(TAB_STOP + 1);

  // Tab length: spaces to the next tab stop, a constant table over all columns
  function automatic logic [RW-1:0] tab_len(logic [7:0] col);
    logic [RW-1:0] len;
    int unsigned   r;
    len = '0;
    r   = 0;
    for (int unsigned i = 0; i < 256; i++) begin
      if (col == 8'(i)) begin
        len = RW'(TAB_STOP - r);
      end
      r = (r == TAB_STOP - 1) ? 0 : r + 1;
    end
    return len;
  endfunction

  // Configuration registers
  logic [7:0] col_cnt_q, row_cnt_q;
  logic [7:0] cols_eff, rows_eff;

  // Input register
  logic                 in_valid_q;
  logic [7:0]           in_code_q;
  logic [31:0]          in_fg_q, in_bg_q;

  // Emit sequencer
  logic                 busy_q, busy_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic                 adv_q, adv_d;
  logic [7:0]           glyph_q, glyph_d;
  logic [31:0]          job_fg_q, job_bg_q;

  // Cursor
  cursor_t              cur_q, cur_d;

  // Output register
  logic                 out_valid_q;
  logic [7:0]           out_col_q, out_row_q, out_glyph_q;
  logic [31:0]          out_fg_q, out_bg_q;
  logic                 out_last_q;

  logic    emit, job_done, load, accept;
  cursor_t cur_a, cur_w, cur_l;

  assign cfg_ready_o = 1'b1;
  assign cols_eff    = (col_cnt_q == 8'd0) ? 8'd1 : col_cnt_q;
  assign rows_eff    = (row_cnt_q == 8'd0) ? 8'd1 : row_cnt_q;

  // Column overflow to next row, then row overflow to row 0
  function automatic cursor_t wrap_pos(cursor_t p, logic [7:0] cols, logic [7:0] rows);
    cursor_t w;
    w = p;
    if (w.col >= cols) begin
      w.col = 8'd0;
      w.row = w.row + 8'd1;
    end
    if (w.row >= rows) begin
      w.row = 8'd0;
    end
    return w;
  endfunction

  // Handshake and sequencing
  assign emit          = busy_q && (!out_valid_q || m_axis_tready);
  assign job_done      = !busy_q || (emit && (rem_q == RW'(1)));
  assign load          = in_valid_q && job_done;
  assign s_axis_tready = !in_valid_q || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Cursor after this cycle's emit, then the start-of-character wrap
  always_comb begin
    cur_a = cur_q;
    if (emit && adv_q) begin
      cur_a = wrap_pos('{col: cur_q.col + 8'd1, row: cur_q.row}, cols_eff, rows_eff);
    end
    cur_w = wrap_pos(cur_a, cols_eff, rows_eff);
  end

  // Decode of the character in the input register
  always_comb begin
    cur_l   = cur_w;
    busy_d  = 1'b1;
    rem_d   = RW'(1);
    adv_d   = 1'b1;
    glyph_d = in_code_q;
    case (in_code_q)
      CODE_NEWLINE: begin
        busy_d = 1'b0;
        cur_l  = wrap_pos('{col: 8'd0, row: cur_w.row + 8'd1}, cols_eff, rows_eff);
      end
      CODE_BACKSPACE: begin
        adv_d   = 1'b0;
        glyph_d = CODE_SPACE;
        if (cur_w.col == 8'd0) begin
          cur_l.col = cols_eff - 8'd1;
          cur_l.row = (cur_w.row == 8'd0) ? rows_eff - 8'd1 : cur_w.row - 8'd1;
        end else begin
          cur_l.col = cur_w.col - 8'd1;
        end
      end
      CODE_TAB: begin
        glyph_d = CODE_SPACE;
        rem_d   = tab_len(cur_w.col);
      end
      default: begin
        glyph_d = in_code_q;
      end
    endcase
  end

  assign cur_d = load ? cur_l : cur_a;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= COLUMN_COUNT_RST;
      row_cnt_q <= ROW_COUNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_COLUMN_COUNT) begin
        col_cnt_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_ROW_COUNT) begin
        row_cnt_q <= cfg_data_i;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_code_q <= s_axis_tdata[7:0];
      in_fg_q   <= s_axis_tdata[39:8];
      in_bg_q   <= s_axis_tdata[71:40];
    end
  end

  // Cursor and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      cur_q <= cur_d;
      if (load) begin
        busy_q <= busy_d;
        rem_q  <= rem_d;
      end else if (emit) begin
        busy_q <= (rem_q != RW'(1));
        rem_q  <= rem_q - RW'(1);
      end
    end
  end

  // Sequencer payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      adv_q    <= adv_d;
      glyph_q  <= glyph_d;
      job_fg_q <= in_fg_q;
      job_bg_q <= in_bg_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_col_q   <= cur_q.col;
      out_row_q   <= cur_q.row;
      out_glyph_q <= glyph_q;
      out_fg_q    <= job_fg_q;
      out_bg_q    <= job_bg_q;
      out_last_q  <= (rem_q == RW'(1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_bg_q, out_fg_q, out_glyph_q, out_row_q, out_col_q};

endmodule
